// File: design/ahe_pkg.sv
`timescale 1ns / 1ps

package ahe_pkg;

	localparam int NODE_SLOTS  = 513;
	localparam int SYM_SLOTS   = 257;
	localparam int WEIGHT_BITS = 32;
	localparam int NODE_W      = $clog2(NODE_SLOTS);
	localparam int SYM_W       = $clog2(SYM_SLOTS);
	localparam int MAX_PATH    = 256;
	localparam int BUF_BITS    = MAX_PATH + 9;
	localparam int CNT_W       = $clog2(BUF_BITS + 1);
	localparam int PLEN_W      = $clog2(MAX_PATH + 1);
	localparam int STEP_W      = $clog2(NODE_SLOTS + 1);
	localparam int CHUNK_BITS  = 32;
	localparam int STATE_N     = 31;

	localparam logic [SYM_W-1:0]       NYT_SYM = SYM_W'(256);
	localparam logic [NODE_W-1:0]      NO_LINK = '1;
	localparam logic [WEIGHT_BITS-1:0] WMAX    = '1;

	typedef struct packed {
		logic [WEIGHT_BITS-1:0] weight;
		logic [NODE_W-1:0]      left;
		logic [NODE_W-1:0]      right;
		logic                   internal;
		logic [SYM_W-1:0]       sym;
	} node_rec_t;

	localparam int REC_W = $bits(node_rec_t);

	typedef enum logic [STATE_N-1:0] {
		ST_CLEAR     = 31'd1 << 0,
		ST_IDLE      = 31'd1 << 1,
		ST_LOOK1     = 31'd1 << 2,
		ST_LOOK2     = 31'd1 << 3,
		ST_PATH_A    = 31'd1 << 4,
		ST_PATH_B    = 31'd1 << 5,
		ST_PATH_C    = 31'd1 << 6,
		ST_ADD_RD    = 31'd1 << 7,
		ST_ADD_WR    = 31'd1 << 8,
		ST_ADD_WR2   = 31'd1 << 9,
		ST_UPD_START = 31'd1 << 10,
		ST_UPD_W     = 31'd1 << 11,
		ST_UPD_Z1    = 31'd1 << 12,
		ST_UPD_Z2    = 31'd1 << 13,
		ST_LD_RD     = 31'd1 << 14,
		ST_LD_EV     = 31'd1 << 15,
		ST_LD_DONE   = 31'd1 << 16,
		ST_LD_SW2    = 31'd1 << 17,
		ST_LD_PAR    = 31'd1 << 18,
		ST_LD_PN     = 31'd1 << 19,
		ST_LD_WR     = 31'd1 << 20,
		ST_LD_WL     = 31'd1 << 21,
		ST_LOOP      = 31'd1 << 22,
		ST_SL_RD     = 31'd1 << 23,
		ST_SL_EV     = 31'd1 << 24,
		ST_SL_FX     = 31'd1 << 25,
		ST_SL_FIN    = 31'd1 << 26,
		ST_SL_FIN2   = 31'd1 << 27,
		ST_SL_NX     = 31'd1 << 28,
		ST_TAIL      = 31'd1 << 29,
		ST_EMIT      = 31'd1 << 30
	} state_t;

	typedef struct packed {
		logic clr_done;
		logic lk_valid;
		logic eos;
		logic known;
		logic room;
		logic path_stop;
		logic par_invalid;
		logic w_zero;
		logic p_zero;
		logic j_zero;
		logic ld_match;
		logic r_zero;
		logic l_zero;
		logic loop_stop;
		logic sl_match;
		logic tail;
		logic t1_valid;
		logic out_free;
		logic cnt_zero;
		logic cnt_last;
	} status_t;

endpackage

// File: design/ahe_ram.sv
`timescale 1ns / 1ps

module ahe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/ahe_ctrl.sv
`timescale 1ns / 1ps

module ahe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ahe_pkg::status_t  st,
	output ahe_pkg::state_t   cmd,
	output logic              in_ready
);

	ahe_pkg::state_t state_q, state_d, path_exit;

	assign cmd      = state_q;
	assign in_ready = (state_q == ahe_pkg::ST_IDLE);

	always_comb begin
		if (st.eos) begin
			path_exit = ahe_pkg::ST_EMIT;
		end else if (st.known) begin
			path_exit = ahe_pkg::ST_UPD_START;
		end else if (st.room) begin
			path_exit = ahe_pkg::ST_ADD_RD;
		end else begin
			path_exit = ahe_pkg::ST_EMIT;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ahe_pkg::ST_CLEAR:     if (st.clr_done) state_d = ahe_pkg::ST_IDLE;
			ahe_pkg::ST_IDLE:      if (in_valid) state_d = ahe_pkg::ST_LOOK1;
			ahe_pkg::ST_LOOK1: begin
				state_d = (st.eos || st.lk_valid) ? ahe_pkg::ST_PATH_A : ahe_pkg::ST_LOOK2;
			end
			ahe_pkg::ST_LOOK2:     state_d = ahe_pkg::ST_PATH_A;
			ahe_pkg::ST_PATH_A:    state_d = st.path_stop ? path_exit : ahe_pkg::ST_PATH_B;
			ahe_pkg::ST_PATH_B:    state_d = st.par_invalid ? path_exit : ahe_pkg::ST_PATH_C;
			ahe_pkg::ST_PATH_C:    state_d = ahe_pkg::ST_PATH_A;
			ahe_pkg::ST_ADD_RD:    state_d = ahe_pkg::ST_ADD_WR;
			ahe_pkg::ST_ADD_WR:    state_d = ahe_pkg::ST_ADD_WR2;
			ahe_pkg::ST_ADD_WR2:   state_d = ahe_pkg::ST_UPD_START;
			ahe_pkg::ST_UPD_START: state_d = ahe_pkg::ST_UPD_W;
			ahe_pkg::ST_UPD_W: begin
				if (st.w_zero) begin
					state_d = ahe_pkg::ST_UPD_Z1;
				end else if (st.p_zero) begin
					state_d = ahe_pkg::ST_LD_DONE;
				end else begin
					state_d = ahe_pkg::ST_LD_RD;
				end
			end
			ahe_pkg::ST_UPD_Z1:    state_d = st.par_invalid ? ahe_pkg::ST_EMIT : ahe_pkg::ST_UPD_Z2;
			ahe_pkg::ST_UPD_Z2:    state_d = ahe_pkg::ST_LOOP;
			ahe_pkg::ST_LD_RD:     state_d = ahe_pkg::ST_LD_EV;
			ahe_pkg::ST_LD_EV: begin
				state_d = (st.ld_match && !st.j_zero) ? ahe_pkg::ST_LD_RD : ahe_pkg::ST_LD_DONE;
			end
			ahe_pkg::ST_LD_DONE:   state_d = ahe_pkg::ST_LD_SW2;
			ahe_pkg::ST_LD_SW2:    state_d = ahe_pkg::ST_LD_PAR;
			ahe_pkg::ST_LD_PAR:    state_d = st.par_invalid ? ahe_pkg::ST_LOOP : ahe_pkg::ST_LD_PN;
			ahe_pkg::ST_LD_PN:     state_d = ahe_pkg::ST_LD_WR;
			ahe_pkg::ST_LD_WR:     state_d = st.r_zero ? ahe_pkg::ST_LOOP : ahe_pkg::ST_LD_WL;
			ahe_pkg::ST_LD_WL:     state_d = ahe_pkg::ST_LOOP;
			ahe_pkg::ST_LOOP:      state_d = st.loop_stop ? ahe_pkg::ST_TAIL : ahe_pkg::ST_SL_RD;
			ahe_pkg::ST_SL_RD:     state_d = st.p_zero ? ahe_pkg::ST_SL_FIN : ahe_pkg::ST_SL_EV;
			ahe_pkg::ST_SL_EV:     state_d = st.sl_match ? ahe_pkg::ST_SL_FX : ahe_pkg::ST_SL_FIN;
			ahe_pkg::ST_SL_FX:     state_d = st.j_zero ? ahe_pkg::ST_SL_FIN : ahe_pkg::ST_SL_EV;
			ahe_pkg::ST_SL_FIN:    state_d = ahe_pkg::ST_SL_FIN2;
			ahe_pkg::ST_SL_FIN2:   state_d = ahe_pkg::ST_SL_NX;
			ahe_pkg::ST_SL_NX:     state_d = st.tail ? ahe_pkg::ST_EMIT : ahe_pkg::ST_LOOP;
			ahe_pkg::ST_TAIL:      state_d = st.t1_valid ? ahe_pkg::ST_SL_RD : ahe_pkg::ST_EMIT;
			ahe_pkg::ST_EMIT: begin
				if (st.cnt_zero || (st.out_free && st.cnt_last)) begin
					state_d = ahe_pkg::ST_IDLE;
				end
			end
			default:               state_d = ahe_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ahe_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: design/ahe_datapath.sv
`timescale 1ns / 1ps

module ahe_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  ahe_pkg::state_t  cmd,
	input  logic             in_valid,
	input  logic [7:0]       symbol,
	input  logic             end_of_stream,
	input  logic             out_ready,
	output ahe_pkg::status_t st,
	output logic [31:0]      code_bits,
	output logic [5:0]       bit_count,
	output logic             last_chunk,
	output logic             weight_overflow,
	output logic             out_valid
);

	localparam int NW = ahe_pkg::NODE_W;
	localparam int SW = ahe_pkg::SYM_W;

	function automatic logic vld(input logic [ahe_pkg::NODE_W-1:0] x,
			input logic [ahe_pkg::NODE_W-1:0] nc);
		return x < nc;
	endfunction

	// node records, parent links and symbol map
	logic                 n_we, p_we, s_we;
	logic [NW-1:0]        n_waddr, n_raddr, p_waddr, p_raddr;
	logic [SW-1:0]        s_waddr, s_raddr;
	ahe_pkg::node_rec_t   n_wdata, n_rd;
	logic [NW-1:0]        p_wdata, p_rd, s_wdata, s_rd;
	logic [ahe_pkg::REC_W-1:0] n_rd_raw;

	assign n_rd = ahe_pkg::node_rec_t'(n_rd_raw);

	ahe_ram #(.WIDTH(ahe_pkg::REC_W), .DEPTH(ahe_pkg::NODE_SLOTS)) u_node_ram (
		.clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.raddr(n_raddr), .rdata(n_rd_raw)
	);

	ahe_ram #(.WIDTH(NW), .DEPTH(ahe_pkg::NODE_SLOTS)) u_parent_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rd)
	);

	ahe_ram #(.WIDTH(NW), .DEPTH(ahe_pkg::SYM_SLOTS)) u_sym_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(s_raddr), .rdata(s_rd)
	);

	logic [NW-1:0]                    nc_q, clr_q;
	logic                             ov_q;
	logic [7:0]                       sym_q;
	logic                             eos_q, known_q, tail_q, ovf_q;
	logic [NW-1:0]                    n_q, par_q, nyt_q, p_q, j_q, lst_q;
	logic [NW-1:0]                    t0_q, t1_q, lnk_l_q, lnk_r_q;
	logic [ahe_pkg::STEP_W-1:0]       steps_q;
	logic [ahe_pkg::PLEN_W-1:0]       plen_q;
	logic [ahe_pkg::CNT_W-1:0]        cnt_q;
	logic [ahe_pkg::BUF_BITS-1:0]     buf_q;
	ahe_pkg::node_rec_t               cur_q, oth_q;
	logic [31:0]                      code_q;
	logic [5:0]                       bcnt_q;
	logic                             last_q, wovf_q;

	logic [NW-1:0]  jm1, jp1, nc_p1;
	logic [31:0]    chunk;
	logic           emit_fire;

	assign jm1   = j_q - NW'(1);
	assign jp1   = j_q + NW'(1);
	assign nc_p1 = nc_q + NW'(1);
	assign chunk = buf_q[ahe_pkg::BUF_BITS-1 -: ahe_pkg::CHUNK_BITS];

	always_comb begin
		st.clr_done    = (clr_q == NW'(ahe_pkg::NODE_SLOTS - 1));
		st.lk_valid    = vld(s_rd, nc_q);
		st.eos         = eos_q;
		st.known       = known_q;
		st.room        = ({1'b0, nc_q} + (NW + 1)'(2)) <= (NW + 1)'(ahe_pkg::NODE_SLOTS);
		st.path_stop   = !vld(n_q, nc_q) || (plen_q == ahe_pkg::PLEN_W'(ahe_pkg::MAX_PATH));
		st.par_invalid = !vld(p_rd, nc_q);
		st.w_zero      = (n_rd.weight == '0);
		st.p_zero      = (p_q == '0);
		st.j_zero      = (j_q == '0);
		st.ld_match    = (n_rd.weight == cur_q.weight) && (n_rd.internal == cur_q.internal);
		st.r_zero      = !vld(lnk_r_q, nc_q) || (n_rd.weight == '0);
		st.l_zero      = !vld(lnk_l_q, nc_q) || (n_rd.weight == '0);
		st.loop_stop   = !vld(p_q, nc_q) ||
			(steps_q == ahe_pkg::STEP_W'(ahe_pkg::NODE_SLOTS));
		if (cur_q.internal) begin
			st.sl_match = !n_rd.internal && (cur_q.weight != ahe_pkg::WMAX) &&
				(n_rd.weight == cur_q.weight + ahe_pkg::WEIGHT_BITS'(1));
		end else begin
			st.sl_match = n_rd.internal && (n_rd.weight == cur_q.weight);
		end
		st.tail        = tail_q;
		st.t1_valid    = vld(t1_q, nc_q);
		st.out_free    = !ov_q || out_ready;
		st.cnt_zero    = (cnt_q == '0);
		st.cnt_last    = (cnt_q <= ahe_pkg::CNT_W'(ahe_pkg::CHUNK_BITS));
	end

	assign emit_fire = (cmd == ahe_pkg::ST_EMIT) && st.out_free && !st.cnt_zero;

	// memory port control
	always_comb begin
		n_we = 1'b0; n_waddr = '0; n_wdata = '0; n_raddr = '0;
		p_we = 1'b0; p_waddr = '0; p_wdata = '0; p_raddr = '0;
		s_we = 1'b0; s_waddr = '0; s_wdata = '0; s_raddr = '0;
		case (cmd)
			ahe_pkg::ST_CLEAR: begin
				n_we = 1'b1;
				n_waddr = clr_q;
				n_wdata.sym = (clr_q == '0) ? ahe_pkg::NYT_SYM : '0;
				p_we = 1'b1;
				p_waddr = clr_q;
				p_wdata = ahe_pkg::NO_LINK;
				s_we = (clr_q < NW'(ahe_pkg::SYM_SLOTS));
				s_waddr = clr_q[SW-1:0];
				s_wdata = (clr_q[SW-1:0] == ahe_pkg::NYT_SYM) ? '0 : ahe_pkg::NO_LINK;
			end
			ahe_pkg::ST_IDLE: begin
				s_raddr = end_of_stream ? ahe_pkg::NYT_SYM : {1'b0, symbol};
			end
			ahe_pkg::ST_LOOK1:  s_raddr = ahe_pkg::NYT_SYM;
			ahe_pkg::ST_PATH_A: p_raddr = n_q;
			ahe_pkg::ST_PATH_B: n_raddr = p_rd;
			ahe_pkg::ST_ADD_RD: begin
				n_raddr = nyt_q;
				n_we = 1'b1;
				n_waddr = nc_q;
				n_wdata.sym = {1'b0, sym_q};
				p_we = 1'b1;
				p_waddr = nc_q;
				p_wdata = nyt_q;
				s_we = 1'b1;
				s_waddr = ahe_pkg::NYT_SYM;
				s_wdata = nc_p1;
			end
			ahe_pkg::ST_ADD_WR: begin
				n_we = 1'b1;
				n_waddr = nyt_q;
				n_wdata = n_rd;
				n_wdata.left = nc_p1;
				n_wdata.right = nc_q;
				n_wdata.internal = 1'b1;
				p_we = 1'b1;
				p_waddr = nc_p1;
				p_wdata = nyt_q;
				s_we = 1'b1;
				s_waddr = {1'b0, sym_q};
				s_wdata = nc_q;
			end
			ahe_pkg::ST_ADD_WR2: begin
				n_we = 1'b1;
				n_waddr = nc_p1;
				n_wdata.sym = ahe_pkg::NYT_SYM;
			end
			ahe_pkg::ST_UPD_START: n_raddr = p_q;
			ahe_pkg::ST_UPD_W:     p_raddr = p_q;
			ahe_pkg::ST_UPD_Z1:    n_raddr = p_rd;
			ahe_pkg::ST_LD_RD:     n_raddr = j_q;
			ahe_pkg::ST_LD_DONE: begin
				if (lst_q != p_q) begin
					n_we = 1'b1;
					n_waddr = p_q;
					n_wdata = cur_q;
					n_wdata.sym = oth_q.sym;
					s_we = !cur_q.internal && (oth_q.sym < SW'(ahe_pkg::SYM_SLOTS));
					s_waddr = oth_q.sym;
					s_wdata = p_q;
				end
			end
			ahe_pkg::ST_LD_SW2: begin
				p_raddr = lst_q;
				if (lst_q != p_q) begin
					n_we = 1'b1;
					n_waddr = lst_q;
					n_wdata = oth_q;
					n_wdata.sym = cur_q.sym;
					s_we = !oth_q.internal && (cur_q.sym < SW'(ahe_pkg::SYM_SLOTS));
					s_waddr = cur_q.sym;
					s_wdata = lst_q;
				end
			end
			ahe_pkg::ST_LD_PAR: n_raddr = p_rd;
			ahe_pkg::ST_LD_PN:  n_raddr = n_rd.right;
			ahe_pkg::ST_LD_WR:  n_raddr = lnk_l_q;
			ahe_pkg::ST_LOOP: begin
				n_raddr = p_q;
				p_raddr = p_q;
			end
			ahe_pkg::ST_TAIL: begin
				n_raddr = t1_q;
				p_raddr = t1_q;
			end
			ahe_pkg::ST_SL_RD: n_raddr = p_q - NW'(1);
			ahe_pkg::ST_SL_EV: begin
				if (st.sl_match) begin
					n_we = 1'b1;
					n_waddr = j_q;
					n_wdata = n_rd;
					if (n_rd.internal) begin
						p_we = vld(n_rd.left, nc_q);
						p_waddr = n_rd.left;
						p_wdata = j_q;
					end else begin
						s_we = (n_rd.sym < SW'(ahe_pkg::SYM_SLOTS));
						s_waddr = n_rd.sym;
						s_wdata = j_q;
					end
				end
			end
			ahe_pkg::ST_SL_FX: begin
				n_raddr = jm1;
				p_we = oth_q.internal && vld(oth_q.right, nc_q);
				p_waddr = oth_q.right;
				p_wdata = jp1;
			end
			ahe_pkg::ST_SL_FIN: begin
				n_we = 1'b1;
				n_waddr = j_q;
				n_wdata = cur_q;
				if (cur_q.weight != ahe_pkg::WMAX) begin
					n_wdata.weight = cur_q.weight + ahe_pkg::WEIGHT_BITS'(1);
				end
				if (cur_q.internal) begin
					p_we = vld(cur_q.left, nc_q);
					p_waddr = cur_q.left;
					p_wdata = j_q;
				end else begin
					s_we = (cur_q.sym < SW'(ahe_pkg::SYM_SLOTS));
					s_waddr = cur_q.sym;
					s_wdata = j_q;
				end
			end
			ahe_pkg::ST_SL_FIN2: begin
				p_raddr = j_q;
				p_we = cur_q.internal && vld(cur_q.right, nc_q);
				p_waddr = cur_q.right;
				p_wdata = j_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q  <= NW'(1);
			clr_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (cmd == ahe_pkg::ST_CLEAR && !st.clr_done) begin
				clr_q <= clr_q + NW'(1);
			end
			if (cmd == ahe_pkg::ST_ADD_WR2) begin
				nc_q <= nc_q + NW'(2);
			end
			if (emit_fire) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cmd)
			ahe_pkg::ST_IDLE: begin
				if (in_valid) begin
					sym_q <= symbol;
					eos_q <= end_of_stream;
					ovf_q <= 1'b0;
				end
			end
			ahe_pkg::ST_LOOK1: begin
				plen_q <= '0;
				if (eos_q) begin
					known_q <= 1'b0;
					n_q <= s_rd;
					buf_q <= {{9{1'b1}}, {(ahe_pkg::BUF_BITS-9){1'b0}}};
					cnt_q <= ahe_pkg::CNT_W'(9);
				end else if (st.lk_valid) begin
					known_q <= 1'b1;
					n_q <= s_rd;
					p_q <= s_rd;
					buf_q <= '0;
					cnt_q <= '0;
				end else begin
					known_q <= 1'b0;
					buf_q <= {1'b0, sym_q, {(ahe_pkg::BUF_BITS-9){1'b0}}};
					cnt_q <= ahe_pkg::CNT_W'(9);
				end
			end
			ahe_pkg::ST_LOOK2: begin
				n_q <= s_rd;
				nyt_q <= s_rd;
			end
			ahe_pkg::ST_PATH_B: par_q <= p_rd;
			ahe_pkg::ST_PATH_C: begin
				buf_q <= {(n_rd.left != n_q), buf_q[ahe_pkg::BUF_BITS-1:1]};
				cnt_q <= cnt_q + ahe_pkg::CNT_W'(1);
				plen_q <= plen_q + ahe_pkg::PLEN_W'(1);
				n_q <= par_q;
			end
			ahe_pkg::ST_ADD_RD: p_q <= nc_q;
			ahe_pkg::ST_UPD_START: begin
				t1_q <= ahe_pkg::NO_LINK;
				steps_q <= '0;
				tail_q <= 1'b0;
			end
			ahe_pkg::ST_UPD_W: begin
				cur_q <= n_rd;
				oth_q <= n_rd;
				lst_q <= p_q;
				j_q <= p_q - NW'(1);
			end
			ahe_pkg::ST_UPD_Z1: par_q <= p_rd;
			ahe_pkg::ST_UPD_Z2: begin
				t1_q <= n_rd.right;
				p_q <= par_q;
			end
			ahe_pkg::ST_LD_EV: begin
				if (st.ld_match) begin
					lst_q <= j_q;
					oth_q <= n_rd;
					j_q <= jm1;
				end
			end
			ahe_pkg::ST_LD_SW2: p_q <= lst_q;
			ahe_pkg::ST_LD_PAR: par_q <= p_rd;
			ahe_pkg::ST_LD_PN: begin
				lnk_l_q <= n_rd.left;
				lnk_r_q <= n_rd.right;
			end
			ahe_pkg::ST_LD_WR: begin
				if (st.r_zero) begin
					t1_q <= p_q;
					p_q <= par_q;
				end
			end
			ahe_pkg::ST_LD_WL: begin
				if (st.l_zero) begin
					t1_q <= p_q;
					p_q <= par_q;
				end
			end
			ahe_pkg::ST_LOOP: steps_q <= steps_q + ahe_pkg::STEP_W'(1);
			ahe_pkg::ST_SL_RD: begin
				cur_q <= n_rd;
				t0_q <= p_rd;
				j_q <= p_q;
			end
			ahe_pkg::ST_SL_EV: begin
				oth_q <= n_rd;
				if (st.sl_match) begin
					j_q <= jm1;
					if (t0_q == jm1) begin
						t0_q <= j_q;
					end else if (t0_q == j_q) begin
						t0_q <= jm1;
					end
					if (t1_q == jm1) begin
						t1_q <= j_q;
					end else if (t1_q == j_q) begin
						t1_q <= jm1;
					end
				end
			end
			ahe_pkg::ST_SL_FIN: begin
				if (cur_q.weight == ahe_pkg::WMAX) begin
					ovf_q <= 1'b1;
				end
			end
			ahe_pkg::ST_SL_NX: p_q <= cur_q.internal ? t0_q : p_rd;
			ahe_pkg::ST_TAIL: begin
				p_q <= t1_q;
				tail_q <= 1'b1;
			end
			ahe_pkg::ST_EMIT: begin
				if (emit_fire) begin
					buf_q <= buf_q << ahe_pkg::CHUNK_BITS;
					cnt_q <= cnt_q - ahe_pkg::CNT_W'(ahe_pkg::CHUNK_BITS);
				end
			end
			default: ;
		endcase
		if (emit_fire) begin
			if (st.cnt_last) begin
				code_q <= chunk >> (6'd32 - cnt_q[5:0]);
				bcnt_q <= (cnt_q == ahe_pkg::CNT_W'(32)) ? 6'd32 : cnt_q[5:0];
			end else begin
				code_q <= chunk;
				bcnt_q <= 6'd32;
			end
			last_q <= st.cnt_last;
			wovf_q <= ovf_q;
		end
	end

	assign code_bits       = code_q;
	assign bit_count       = bcnt_q;
	assign last_chunk      = last_q;
	assign weight_overflow = wovf_q;
	assign out_valid       = ov_q;

endmodule

// File: design/adaptive_huffman_encoder.sv
`timescale 1ns / 1ps

// adaptive huffman encoder, one byte per input item
// input channel: symbol and end_of_stream with in_valid / in_ready
// output channel: code_bits, bit_count, last_chunk, weight_overflow with
// out_valid / out_ready; each input item gives 1 to 9 output chunks of up
// to 32 bits, the first bit sent in the most significant valid position
// after reset a clearing pass initializes the node, parent
// and symbol tables; in_ready stays low during it
// an item goes through a lookup of its symbol and, for a new byte, of the nyt
// leaf, a walk of its code path edge by edge, the split of the nyt leaf for a
// new byte, then, except for an end item or a new byte with the tables full,
// the weight update: a block leader search and a climb through the tree
// levels that slides nodes past their block; every item ends with one chunk
// per cycle while the receiver takes them, all bound by the node table
// in_ready is high only while the block is idle between items
// chunks leave through an output register; a stalled receiver holds the
// block in its chunk emit step, and the next item is accepted while the
// last chunk of the previous one still waits
module adaptive_huffman_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  symbol,
	input  logic        end_of_stream,
	input  logic        in_valid,
	output logic        in_ready,
	output logic [31:0] code_bits,
	output logic [5:0]  bit_count,
	output logic        last_chunk,
	output logic        weight_overflow,
	output logic        out_valid,
	input  logic        out_ready
);

	ahe_pkg::state_t  cmd;
	ahe_pkg::status_t st;

	ahe_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.st(st),
		.cmd(cmd),
		.in_ready(in_ready)
	);

	ahe_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.in_valid(in_valid),
		.symbol(symbol),
		.end_of_stream(end_of_stream),
		.out_ready(out_ready),
		.st(st),
		.code_bits(code_bits),
		.bit_count(bit_count),
		.last_chunk(last_chunk),
		.weight_overflow(weight_overflow),
		.out_valid(out_valid)
	);

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int WATCHDOG_LIMIT = 100000;
	localparam int SLOTS = 513;
	localparam int NOLNK = 1023;

	typedef struct {
		logic [31:0] code;
		logic [5:0]  cnt;
		logic        last;
		logic        ovf;
	} chunk_t;

	logic        clk;
	logic        arst_n;
	logic [7:0]  symbol;
	logic        end_of_stream;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] code_bits;
	logic [5:0]  bit_count;
	logic        last_chunk;
	logic        weight_overflow;
	logic        out_valid;
	logic        out_ready;

	chunk_t pending_chunks[$];
	int     fail_count;
	int     quiet_cycles;
	int     send_idle_pct;
	int     recv_stall_pct;

	// tree state of the predictor
	logic [ahe_pkg::WEIGHT_BITS-1:0] t_wgt[SLOTS];
	int                     t_par[SLOTS];
	int                     t_lft[SLOTS];
	int                     t_rgt[SLOTS];
	bit                     t_int[SLOTS];
	int                     t_n2s[SLOTS];
	int                     t_s2n[257];
	int                     t_cnt;
	int                     t_trk[2];
	bit                     t_ovf;

	adaptive_huffman_encoder dut (
		.clk(clk), .arst_n(arst_n), .symbol(symbol), .end_of_stream(end_of_stream),
		.in_valid(in_valid), .in_ready(in_ready), .code_bits(code_bits),
		.bit_count(bit_count), .last_chunk(last_chunk),
		.weight_overflow(weight_overflow), .out_valid(out_valid), .out_ready(out_ready)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic bit in_tree(int p);
		return p >= 0 && p < t_cnt && p < SLOTS;
	endfunction

	function automatic void tree_reset();
		for (int i = 0; i < SLOTS; i++) begin
			t_wgt[i] = '0;
			t_par[i] = NOLNK;
			t_lft[i] = 0;
			t_rgt[i] = 0;
			t_int[i] = 0;
			t_n2s[i] = 0;
		end
		for (int i = 0; i < 257; i++)
			t_s2n[i] = NOLNK;
		t_s2n[256] = 0;
		t_n2s[0] = 256;
		t_cnt = 1;
		t_trk[0] = NOLNK;
		t_trk[1] = NOLNK;
		t_ovf = 0;
	endfunction

	function automatic void relabel(int pos);
		if (!t_int[pos] && t_n2s[pos] < 257)
			t_s2n[t_n2s[pos]] = pos;
	endfunction

	function automatic void swap_nodes(int a, int b);
		logic [ahe_pkg::WEIGHT_BITS-1:0] tw;
		int t;
		bit ti;
		int pos;
		tw = t_wgt[a]; t_wgt[a] = t_wgt[b]; t_wgt[b] = tw;
		ti = t_int[a]; t_int[a] = t_int[b]; t_int[b] = ti;
		t = t_lft[a]; t_lft[a] = t_lft[b]; t_lft[b] = t;
		t = t_rgt[a]; t_rgt[a] = t_rgt[b]; t_rgt[b] = t;
		t = t_n2s[a]; t_n2s[a] = t_n2s[b]; t_n2s[b] = t;
		for (int k = 0; k < 2; k++) begin
			pos = k ? b : a;
			if (t_int[pos]) begin
				if (in_tree(t_lft[pos]))
					t_par[t_lft[pos]] = pos;
				if (in_tree(t_rgt[pos]))
					t_par[t_rgt[pos]] = pos;
			end else begin
				relabel(pos);
			end
		end
		for (int k = 0; k < 2; k++) begin
			if (t_trk[k] == a)
				t_trk[k] = b;
			else if (t_trk[k] == b)
				t_trk[k] = a;
		end
	endfunction

	function automatic int slide_and_bump(int p);
		logic [ahe_pkg::WEIGHT_BITS-1:0] w;
		bit is_int;
		bit match;
		int j;
		int q;
		w = t_wgt[p];
		is_int = t_int[p];
		j = p;
		t_trk[0] = t_par[p];
		while (j > 0) begin
			q = j - 1;
			if (is_int)
				match = !t_int[q] && w != ahe_pkg::WMAX && t_wgt[q] == w + 1'b1;
			else
				match = t_int[q] && t_wgt[q] == w;
			if (!match)
				break;
			swap_nodes(q, j);
			j = q;
		end
		if (t_wgt[j] == ahe_pkg::WMAX)
			t_ovf = 1;
		else
			t_wgt[j] = t_wgt[j] + 1'b1;
		return is_int ? t_trk[0] : t_par[j];
	endfunction

	function automatic int block_leader(int p);
		logic [ahe_pkg::WEIGHT_BITS-1:0] w;
		bit ty;
		int last;
		int j;
		int s;
		w = t_wgt[p];
		ty = t_int[p];
		last = p;
		j = p;
		forever begin
			if (t_wgt[j] != w || t_int[j] != ty)
				break;
			last = j;
			if (j == 0)
				break;
			j--;
		end
		if (last != p) begin
			s = t_n2s[p];
			t_n2s[p] = t_n2s[last];
			t_n2s[last] = s;
			relabel(p);
			relabel(last);
		end
		return last;
	endfunction

	function automatic void grow_tree(int s);
		int nyt;
		int r;
		int l;
		nyt = t_s2n[256];
		r = t_cnt;
		l = t_cnt + 1;
		t_wgt[r] = '0; t_wgt[l] = '0;
		t_int[r] = 0; t_int[l] = 0;
		t_par[r] = nyt; t_par[l] = nyt;
		t_lft[r] = 0; t_rgt[r] = 0;
		t_lft[l] = 0; t_rgt[l] = 0;
		t_n2s[l] = 256;
		t_n2s[r] = s;
		t_s2n[256] = l;
		t_s2n[s] = r;
		t_cnt += 2;
		if (nyt < SLOTS) begin
			t_lft[nyt] = l;
			t_rgt[nyt] = r;
			t_int[nyt] = 1;
		end
	endfunction

	function automatic void bump_weights(int s);
		int p;
		int par;
		int steps;
		p = t_s2n[s];
		steps = 0;
		t_trk[1] = NOLNK;
		if (!in_tree(p))
			return;
		if (t_wgt[p] == 0) begin
			par = t_par[p];
			if (!in_tree(par))
				return;
			t_trk[1] = t_rgt[par];
			p = par;
		end else begin
			p = block_leader(p);
			par = t_par[p];
			if (in_tree(par) && ((in_tree(t_rgt[par]) ? t_wgt[t_rgt[par]] : 0) == 0 ||
					(in_tree(t_lft[par]) ? t_wgt[t_lft[par]] : 0) == 0)) begin
				t_trk[1] = p;
				p = par;
			end
		end
		while (in_tree(p) && steps < SLOTS) begin
			p = slide_and_bump(p);
			steps++;
		end
		if (in_tree(t_trk[1]))
			void'(slide_and_bump(t_trk[1]));
	endfunction

	function automatic void append_path(int n, ref bit bits[$]);
		bit tmp[$];
		int par;
		while (in_tree(n) && tmp.size() < 256) begin
			par = t_par[n];
			if (!in_tree(par))
				break;
			tmp = {bit'(t_lft[par] != n), tmp};
			n = par;
		end
		bits = {bits, tmp};
	endfunction

	function automatic void encode_symbol(logic [7:0] s, logic eos);
		bit bits[$];
		int n;
		int chunks;
		int len;
		chunk_t c;
		t_ovf = 0;
		if (eos) begin
			append_path(t_s2n[256], bits);
			repeat (9) bits = {bits, 1'b1};
		end else begin
			n = t_s2n[s];
			if (in_tree(n)) begin
				append_path(n, bits);
				bump_weights(s);
			end else begin
				append_path(t_s2n[256], bits);
				bits = {bits, 1'b0};
				for (int k = 7; k >= 0; k--)
					bits = {bits, bit'(s[k])};
				if (t_cnt + 2 <= SLOTS) begin
					grow_tree(s);
					bump_weights(s);
				end
			end
		end
		chunks = (bits.size() + 31) / 32;
		for (int k = 0; k < chunks; k++) begin
			len = bits.size() - k * 32;
			if (len > 32)
				len = 32;
			c.code = '0;
			for (int b = 0; b < len; b++)
				c.code = {c.code[30:0], bits[k * 32 + b]};
			c.cnt = len[5:0];
			c.last = (k + 1 == chunks);
			c.ovf = t_ovf;
			pending_chunks = {pending_chunks, c};
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// result checker, receiver stall and watchdog
	always @(posedge clk) begin
		chunk_t c;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout at %0t", $realtime);
				$display("** adaptive_huffman_encoder: FAILED **");
				$finish;
			end
			if (out_valid && out_ready) begin
				if (pending_chunks.size() == 0) begin
					report_mismatch("unexpected chunk", code_bits, 0);
				end else begin
					c = pending_chunks.pop_front();
					if (code_bits !== c.code)
						report_mismatch("code_bits", code_bits, c.code);
					if (bit_count !== c.cnt)
						report_mismatch("bit_count", bit_count, c.cnt);
					if (last_chunk !== c.last)
						report_mismatch("last_chunk", last_chunk, c.last);
					if (weight_overflow !== c.ovf)
						report_mismatch("weight_overflow", weight_overflow, c.ovf);
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_item(logic [7:0] s, logic eos);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1;
		symbol <= s;
		end_of_stream <= eos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		encode_symbol(s, eos);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_chunks.size() > 0)
			@(posedge clk);
	endtask

	// skewed choice gives deep trees and long codes
	function automatic logic [7:0] skewed_symbol(logic [7:0] base);
		int k;
		k = 0;
		while (k < 14 && $urandom_range(1) == 1)
			k++;
		return base + 8'(k * 37);
	endfunction

	task automatic test_directed();
		send_item(8'h00, 1);
		send_item(8'h00, 0);
		send_item(8'hff, 0);
		send_item(8'h00, 0);
		send_item(8'hff, 0);
		send_item(8'hff, 0);
		send_item(8'h55, 0);
		send_item(8'haa, 1);
		send_item(8'haa, 0);
		send_item(8'h01, 0);
		send_item(8'h80, 0);
		for (int i = 0; i < 8; i++)
			send_item(8'h01, 0);
		send_item(8'h80, 0);
		send_item(8'h7f, 0);
		send_item(8'h00, 1);
		send_item(8'h00, 0);
	endtask

	task automatic test_random(int n);
		logic [7:0] base;
		int r;
		base = 8'($urandom);
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 80)
				send_item(skewed_symbol(base), 0);
			else if (r < 95)
				send_item(8'($urandom), 0);
			else
				send_item(8'($urandom), 1);
		end
	endtask

	task automatic test_pressure();
		drain();
		send_item(8'($urandom), 0);
		send_item(8'h00, 1);
	endtask

	initial begin
		fail_count = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 0;
		in_valid = 0;
		symbol = '0;
		end_of_stream = 0;
		out_ready = 0;
		tree_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		test_directed();
		test_random(60);
		send_idle_pct = 74;
		test_random(60);
		send_idle_pct = 0;
		recv_stall_pct = 74;
		test_random(60);
		test_pressure();
		send_idle_pct = 6;
		recv_stall_pct = 6;
		test_random(60);
		drain();
		repeat (2000) @(posedge clk);
		if (fail_count == 0)
			$display("** adaptive_huffman_encoder: PASSED **");
		else
			$display("** adaptive_huffman_encoder: FAILED **");
		$finish;
	end

endmodule
